FILE: rtl/riff_wave_stream_parser_top_defines.svh
// assertion macros of the riff wave stream parser, used by the result queue
`ifndef RIFF_WAVE_STREAM_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_STREAM_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is held
`define RWSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define RWSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RWSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RWSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/rwsp_pkg.sv
// types and constants of the riff wave stream parser
package rwsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] PCM_TAG     = 16'd1;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_CONTAINER = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_FMT_SMALL = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_UNSUPP    = 3'd4;
    localparam logic [2:0] ERR_MISSING   = 3'd5;
    localparam logic [2:0] ERR_RIFF_ZERO = 3'd6;

    // result queue, depth must be a power of two of at least four
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic [1:0]  audio_format;
        logic [31:0] sample_rate;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // up to two results per input byte, r1 only with r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

FILE: rtl/riff_wave_stream_parser_top.sv
// top level of the riff wave stream parser: input register, parser, result queue
//
// channel   dir   handshake                         payload
// s_axis    in    i_s_axis_tvalid / o_s_axis_tready  tdata byte_value, tuser func
// m_axis    out   o_m_axis_tvalid / i_m_axis_tready  tdata result fields, tuser kind, tlast
//
// one beat accepted per cycle while tready is high; each beat is parsed in the cycle after
// it is taken, and its results sit in the queue in the cycle after that
// a beat yields up to two results; the queue takes both at once and drains one per
// cycle while m_axis_tready is high; tready drops when the queue could not hold two
// more results for both the beat in the input register and a new one, i.e. with a
// sustained two-result pattern the rate is set by the single read port of the queue
// synchronous active-low reset clears the parser and the queue; no clearing pass
module riff_wave_stream_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic [0:0]  i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] sample_byte, [9:8] audio_format,
                                          // [41:10] sample_rate, [44:42] error_code,
                                          // [47:45] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last result of an input beat
);

    localparam int CNT_W = rwsp_pkg::CNT_W;

    // input register
    logic              r_in_valid;
    logic              r_in_func;
    logic [7:0]        r_in_byte;

    logic              s_accept;
    logic [CNT_W:0]    room_need;
    rwsp_pkg::t_push   push;
    rwsp_pkg::t_result head;
    logic [CNT_W-1:0]  q_count;

    // queue count plus worst case of the beat already in flight
    assign room_need       = {1'b0, q_count} + {{(CNT_W-1){1'b0}}, r_in_valid, 1'b0};
    assign o_s_axis_tready = (room_need <= (CNT_W+1)'(rwsp_pkg::FIFO_DEPTH - 2));
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_func <= i_s_axis_tuser[0];
            r_in_byte <= i_s_axis_tdata;
        end
    end

    rwsp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_func  (r_in_func),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    rwsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (head),
        .o_count (q_count)
    );

    // pack the result beat
    assign o_m_axis_tdata = {3'b000, head.error_code, head.sample_rate,
                             head.audio_format, head.sample_byte};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

FILE: rtl/rwsp_parser.sv
// parser state and result generation for one registered input beat
module rwsp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_func,
    input  logic [7:0]       i_byte,
    output rwsp_pkg::t_push  o_push
);

    typedef enum logic [2:0] {
        PH_HEAD, PH_HEAD_BAD, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_IDLE
    } t_phase;

    t_phase      r_phase,          n_phase;
    logic [31:0] r_byte_count,     n_byte_count;
    logic [31:0] r_chunk_tag,      n_chunk_tag;
    logic [31:0] r_chunk_length,   n_chunk_length;
    logic [31:0] r_container_size, n_container_size;
    logic [15:0] r_format_tag,     n_format_tag;
    logic [15:0] r_channel_count,  n_channel_count;
    logic [31:0] r_rate_value,     n_rate_value;
    logic [15:0] r_sample_bits,    n_sample_bits;
    logic [1:0]  r_found_flags,    n_found_flags;

    logic [31:0]       cnt;
    logic [31:0]       cnt_inc;
    logic [31:0]       shifted_tag;
    logic [31:0]       len_base;
    logic              done_req;
    logic              pri_v;
    logic              fin_v;
    rwsp_pkg::t_result pri;
    rwsp_pkg::t_result fin;
    logic              ch_ok;
    logic              bits_ok;

    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_chunk_tag      = r_chunk_tag;
        n_chunk_length   = r_chunk_length;
        n_container_size = r_container_size;
        n_format_tag     = r_format_tag;
        n_channel_count  = r_channel_count;
        n_rate_value     = r_rate_value;
        n_sample_bits    = r_sample_bits;
        n_found_flags    = r_found_flags;
        cnt              = r_byte_count;
        cnt_inc          = r_byte_count + 32'd1;
        shifted_tag      = {r_chunk_tag[23:0], i_byte};
        len_base         = (r_byte_count == 32'd0) ? 32'd0 : r_chunk_length;
        done_req         = 1'b0;
        pri_v            = 1'b0;
        fin_v            = 1'b0;
        pri              = '0;
        fin              = '0;
        ch_ok            = 1'b0;
        bits_ok          = 1'b0;

        if (i_valid && i_func) begin
            // end of stream: report and re-arm
            if (r_phase != PH_IDLE) begin
                pri_v      = 1'b1;
                pri.kind   = rwsp_pkg::KIND_ERROR;
                pri.error_code = ((r_phase == PH_CHDR && cnt == 32'd0) ||
                                  r_phase == PH_SKIP || r_phase == PH_PAD) ?
                                 rwsp_pkg::ERR_MISSING : rwsp_pkg::ERR_TRUNCATED;
            end
            n_phase          = PH_HEAD;
            n_byte_count     = '0;
            n_chunk_tag      = '0;
            n_chunk_length   = '0;
            n_container_size = '0;
            n_format_tag     = '0;
            n_channel_count  = '0;
            n_rate_value     = '0;
            n_sample_bits    = '0;
            n_found_flags    = '0;
        end else if (i_valid) begin
            unique case (r_phase)
                PH_HEAD, PH_HEAD_BAD: begin
                    if (cnt < 32'd4 || cnt >= 32'd8) begin
                        n_chunk_tag = shifted_tag;
                    end else begin
                        n_container_size[{cnt[1:0], 3'b000} +: 8] =
                            r_container_size[{cnt[1:0], 3'b000} +: 8] | i_byte;
                    end
                    n_byte_count = cnt_inc;
                    if (cnt == 32'd3 && shifted_tag != rwsp_pkg::TAG_RIFF) begin
                        n_phase = PH_HEAD_BAD;
                    end
                    if (cnt >= 32'd11) begin
                        if (r_phase == PH_HEAD_BAD || shifted_tag != rwsp_pkg::TAG_WAVE) begin
                            n_phase        = PH_IDLE;
                            pri_v          = 1'b1;
                            pri.kind       = rwsp_pkg::KIND_ERROR;
                            pri.error_code = rwsp_pkg::ERR_CONTAINER;
                        end else begin
                            n_phase      = PH_CHDR;
                            n_byte_count = '0;
                        end
                    end
                end
                PH_CHDR: begin
                    n_chunk_length = len_base;
                    if (cnt < 32'd4) begin
                        n_chunk_tag = shifted_tag;
                    end else begin
                        n_chunk_length[{cnt[1:0], 3'b000} +: 8] =
                            len_base[{cnt[1:0], 3'b000} +: 8] | i_byte;
                    end
                    n_byte_count = cnt_inc;
                    if (cnt >= 32'd7) begin
                        n_byte_count = '0;
                        if (n_chunk_tag == rwsp_pkg::TAG_FMT) begin
                            if (n_chunk_length < rwsp_pkg::FMT_MIN_LEN) begin
                                n_phase        = PH_IDLE;
                                pri_v          = 1'b1;
                                pri.kind       = rwsp_pkg::KIND_ERROR;
                                pri.error_code = rwsp_pkg::ERR_FMT_SMALL;
                            end else begin
                                n_phase         = PH_FMT;
                                n_format_tag    = '0;
                                n_channel_count = '0;
                                n_rate_value    = '0;
                                n_sample_bits   = '0;
                            end
                        end else if (n_chunk_tag == rwsp_pkg::TAG_DATA) begin
                            if (n_chunk_length == 32'd0) begin
                                n_found_flags = r_found_flags | 2'b10;
                                done_req      = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end else if (n_chunk_length == 32'd0) begin
                            done_req = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    if (cnt < 32'd2) begin
                        n_format_tag[{cnt[0], 3'b000} +: 8] =
                            r_format_tag[{cnt[0], 3'b000} +: 8] | i_byte;
                    end else if (cnt < 32'd4) begin
                        n_channel_count[{cnt[0], 3'b000} +: 8] =
                            r_channel_count[{cnt[0], 3'b000} +: 8] | i_byte;
                    end else if (cnt < 32'd8) begin
                        n_rate_value[{cnt[1:0], 3'b000} +: 8] =
                            r_rate_value[{cnt[1:0], 3'b000} +: 8] | i_byte;
                    end else if (cnt >= 32'd14 && cnt < 32'd16) begin
                        n_sample_bits[{cnt[0], 3'b000} +: 8] =
                            r_sample_bits[{cnt[0], 3'b000} +: 8] | i_byte;
                    end
                    n_byte_count = cnt_inc;
                    if (cnt >= 32'd15) begin
                        ch_ok   = (n_channel_count == 16'd1) || (n_channel_count == 16'd2);
                        bits_ok = (n_sample_bits == 16'd8) || (n_sample_bits == 16'd16);
                        pri_v   = 1'b1;
                        if (n_format_tag != rwsp_pkg::PCM_TAG) begin
                            n_phase        = PH_IDLE;
                            pri.kind       = rwsp_pkg::KIND_ERROR;
                            pri.error_code = rwsp_pkg::ERR_NOT_PCM;
                        end else if (!(ch_ok && bits_ok)) begin
                            n_phase        = PH_IDLE;
                            pri.kind       = rwsp_pkg::KIND_ERROR;
                            pri.error_code = rwsp_pkg::ERR_UNSUPP;
                        end else begin
                            pri.kind         = rwsp_pkg::KIND_FORMAT;
                            pri.audio_format = {n_channel_count == 16'd2,
                                                n_sample_bits == 16'd16};
                            pri.sample_rate  = n_rate_value;
                            n_found_flags    = r_found_flags | 2'b01;
                            if (r_chunk_length > rwsp_pkg::FMT_MIN_LEN) begin
                                n_phase = PH_SKIP;
                            end else begin
                                done_req = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    pri_v           = 1'b1;
                    pri.kind        = rwsp_pkg::KIND_SAMPLE;
                    pri.sample_byte = i_byte;
                    n_byte_count    = cnt_inc;
                    if (cnt_inc >= r_chunk_length) begin
                        n_found_flags = r_found_flags | 2'b10;
                        done_req      = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_byte_count = cnt_inc;
                    if (cnt_inc >= r_chunk_length) begin
                        done_req = 1'b1;
                    end
                end
                PH_PAD: begin
                    n_phase      = PH_CHDR;
                    n_byte_count = '0;
                end
                PH_IDLE: begin
                end
            endcase

            // end of a chunk: finish or go on to the next chunk header, via a pad byte if the length is odd
            if (done_req) begin
                if (n_found_flags == 2'b11) begin
                    n_phase = PH_IDLE;
                    fin_v   = 1'b1;
                    if (r_container_size == 32'd0) begin
                        fin.kind       = rwsp_pkg::KIND_ERROR;
                        fin.error_code = rwsp_pkg::ERR_RIFF_ZERO;
                    end else begin
                        fin.kind = rwsp_pkg::KIND_DONE;
                    end
                end else begin
                    n_byte_count = '0;
                    n_phase      = n_chunk_length[0] ? PH_PAD : PH_CHDR;
                end
            end
        end

        // compact into the queue slots, last flag on the final one
        pri.last    = ~fin_v;
        fin.last    = 1'b1;
        o_push.v0   = pri_v | fin_v;
        o_push.v1   = pri_v & fin_v;
        o_push.r0   = pri_v ? pri : fin;
        o_push.r1   = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEAD;
            r_byte_count     <= '0;
            r_chunk_tag      <= '0;
            r_chunk_length   <= '0;
            r_container_size <= '0;
            r_format_tag     <= '0;
            r_channel_count  <= '0;
            r_rate_value     <= '0;
            r_sample_bits    <= '0;
            r_found_flags    <= '0;
        end else begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_chunk_tag      <= n_chunk_tag;
            r_chunk_length   <= n_chunk_length;
            r_container_size <= n_container_size;
            r_format_tag     <= n_format_tag;
            r_channel_count  <= n_channel_count;
            r_rate_value     <= n_rate_value;
            r_sample_bits    <= n_sample_bits;
            r_found_flags    <= n_found_flags;
        end
    end

endmodule

FILE: rtl/rwsp_fifo.sv
// result queue taking up to two results per cycle and giving one
`include "riff_wave_stream_parser_top_defines.svh"

module rwsp_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rwsp_pkg::t_push            i_push,
    input  logic                       i_pop,
    output logic                       o_valid,
    output rwsp_pkg::t_result          o_data,
    output logic [rwsp_pkg::CNT_W-1:0] o_count
);

    localparam int PTR_W = rwsp_pkg::PTR_W;
    localparam int CNT_W = rwsp_pkg::CNT_W;

    rwsp_pkg::t_result r_mem [rwsp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              pop_ok;
    logic [CNT_W-1:0]  push_n;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop_ok  = i_pop & o_valid;
    assign push_n  = CNT_W'(i_push.v0) + CNT_W'(i_push.v1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_n[PTR_W-1:0];
        n_rd_ptr = r_rd_ptr + PTR_W'(pop_ok);
        n_count  = r_count + push_n - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `RWSP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(rwsp_pkg::FIFO_DEPTH), "result queue overflow")
    `RWSP_ASSERT_ALWAYS(a_pair_order, i_clk, !(i_push.v1 && !i_push.v0), "second result without first")
    `RWSP_ASSERT(a_pair_last, i_clk, i_rst_n, i_push.v1 |-> (i_push.r1.last && !i_push.r0.last), "bad last flags on result pair")
    `RWSP_ASSERT(a_count_track, i_clk, i_rst_n, ##1 (r_count == $past(r_count) + CNT_W'($past(i_push.v0)) + CNT_W'($past(i_push.v1)) - CNT_W'($past(pop_ok))), "queue count out of step")

endmodule
